// File: hw/rtl/nearest_obstacle_query_engine_core_assert.svh
// Assertion macros shared by the query engine RTL.
`ifndef NEAREST_OBSTACLE_QUERY_ENGINE_CORE_ASSERT_SVH
`define NEAREST_OBSTACLE_QUERY_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NOQE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NOQE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/noqe_pkg.sv
`default_nettype none

package noqe_pkg;

    localparam int MAX_OBSTACLES = 1024;
    localparam int IDX_W   = $clog2(MAX_OBSTACLES);
    localparam int CNT_W   = $clog2(MAX_OBSTACLES + 1);
    localparam int COORD_W = 24;
    localparam int PT_W    = 3 * COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CD_W    = 23;
    localparam int CD2_W   = 2 * CD_W;
    localparam int AB2_W   = 2 * DIFF_W + 1;
    localparam int MAG_W   = 2 * DIFF_W;
    localparam int HIT_W   = 25;
    localparam int BIT_W   = $clog2(HIT_W);
    localparam int MM_W    = 2 * HIT_W;
    localparam int LIMB_W  = 26;
    localparam int WIDE_W  = 2 * LIMB_W;
    localparam int SQ_W    = 2 * WIDE_W;
    localparam int MUL_W   = LIMB_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = SQ_W + 2;
    localparam int STEP_W  = 3;

    localparam logic [CD_W-1:0] CD_RESET = 23'd256;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_LOAD      = 3'd1,
        OP_NEAREST   = 3'd2,
        OP_DIRECTION = 3'd3,
        OP_COLLISION = 3'd4,
        OP_RAY       = 3'd5
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRE_CD,
        ST_PRE_AB,
        ST_PRE_RHS,
        ST_PRE_END,
        ST_RD,
        ST_DIFF,
        ST_DOT,
        ST_DOT_CHK,
        ST_DIST,
        ST_DIST_CHK,
        ST_CROSS,
        ST_DT,
        ST_CR2,
        ST_RAY_CHK,
        ST_SQ,
        ST_LH,
        ST_MM,
        ST_MMAB,
        ST_BIT_CHK,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_mode_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_LIMB,
        SH_LIMB2
    } acc_shift_t;

    // products issued by each multiply-accumulate state
    function automatic logic [STEP_W-1:0] prod_count(input state_t st);
        case (st)
            ST_PRE_CD:  prod_count = STEP_W'(1);
            ST_PRE_AB:  prod_count = STEP_W'(2);
            ST_PRE_RHS: prod_count = STEP_W'(4);
            ST_DOT:     prod_count = STEP_W'(3);
            ST_DIST:    prod_count = STEP_W'(3);
            ST_CROSS:   prod_count = STEP_W'(2);
            ST_DT:      prod_count = STEP_W'(2);
            ST_CR2:     prod_count = STEP_W'(4);
            ST_SQ:      prod_count = STEP_W'(4);
            ST_MM:      prod_count = STEP_W'(1);
            ST_MMAB:    prod_count = STEP_W'(4);
            default:    prod_count = STEP_W'(0);
        endcase
    endfunction

    // one unsigned limb of a wide word, as a signed multiplier operand
    function automatic logic signed [MUL_W-1:0] limb(input logic [WIDE_W-1:0] v,
                                                     input logic hi);
        logic [LIMB_W-1:0] l;
        l = hi ? v[WIDE_W-1:LIMB_W] : v[LIMB_W-1:0];
        limb = $signed({1'b0, l});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/noqe_ram.sv
`default_nettype none

module noqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/nearest_obstacle_query_engine_core.sv
// Clear, load and unused ops go straight to the output; any query on an empty store
// ends before the point scan, as does a ray whose two ends share x and y. Other queries
// scan the stored points; collision stops on a hit; a ray hit adds a distance search.
// Throughput: one transaction at a time; the input stalls until the result is
// handed to the output register. The shared 27x27 multiplier sets the per-point cost.
// Reset (rst_n, async, active low): store empty, collision_distance = 256, idle.
`default_nettype none
`include "nearest_obstacle_query_engine_core_assert.svh"

module nearest_obstacle_query_engine_core
    import noqe_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // config
    input  wire logic                      cfg_we,
    input  wire logic [CD_W-1:0]           cfg_wdata,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                op,
    input  wire logic signed [COORD_W-1:0] query_x,
    input  wire logic signed [COORD_W-1:0] query_y,
    input  wire logic signed [COORD_W-1:0] query_z,
    input  wire logic signed [COORD_W-1:0] second_x,
    input  wire logic signed [COORD_W-1:0] second_y,
    input  wire logic signed [COORD_W-1:0] second_z,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           found,
    output logic signed [COORD_W-1:0]      point_x,
    output logic signed [COORD_W-1:0]      point_y,
    output logic signed [COORD_W-1:0]      point_z,
    output logic [IDX_W-1:0]               point_index,
    output logic [HIT_W-1:0]               hit_distance
);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CD_W-1:0]   cd_reg;

    logic in_accept;
    logic out_take;

    // latched transaction
    logic [2:0]                op_reg;
    logic signed [COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [DIFF_W-1:0]  abx_reg, aby_reg;

    // per-query constants
    logic [CD2_W-1:0] cd2_reg;
    logic [AB2_W-1:0] ab2_reg;
    logic [SQ_W-1:0]  rhs_reg;   // cd^2 * |AB|^2
    logic [SQ_W-1:0]  lh_reg;    // best dot^2

    // current point
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;   // query minus point
    logic [MAG_W-1:0]          cr_reg, dt_reg;

    // running result
    logic                      res_found_reg;
    logic signed [COORD_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic [IDX_W-1:0]          res_idx_reg;
    logic [HIT_W-1:0]          res_hit_reg;
    logic [WIDE_W-1:0]         bestd_reg;

    // distance search
    logic [HIT_W-1:0] d_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [MM_W-1:0]  mm_reg;

    // output register
    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [IDX_W-1:0]          out_idx_reg;
    logic [HIT_W-1:0]          out_hit_reg;

    // ------------------------------------------------------------------
    // Shared multiply-accumulate unit: one 27x27 signed multiply per cycle,
    // registered, then shifted by 0/26/52 into a 106-bit accumulator.
    // Wide products are built from four 26-bit limb products.
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    acc_mode_t                iss_mode, mode_reg;
    acc_shift_t               iss_sh, sh_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next, prod_ext, prod_sh;
    logic [ACC_W-1:0]         acc_mag;

    // point store
    logic                 ram_we;
    logic [PT_W-1:0]      ram_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;

    // decisions
    logic [STEP_W-1:0] n_prod;
    logic              issue, mac_done;
    logic              last_pt, best_upd, col_hit, dot_pos, bit_ok, ray_skip;
    logic [WIDE_W-1:0] d_val;
    logic [HIT_W-1:0]  cand;
    logic [HIT_W-1:0]  d_new;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign point_x      = out_x_reg;
    assign point_y      = out_y_reg;
    assign point_z      = out_z_reg;
    assign point_index  = out_idx_reg;
    assign hit_distance = out_hit_reg;

    assign ram_we = in_accept && (op == OP_LOAD) && (count_reg < CNT_W'(MAX_OBSTACLES));
    assign rd_x   = $signed(ram_rdata[COORD_W-1:0]);
    assign rd_y   = $signed(ram_rdata[2*COORD_W-1:COORD_W]);
    assign rd_z   = $signed(ram_rdata[PT_W-1:2*COORD_W]);

    noqe_ram #(
        .WIDTH(PT_W),
        .DEPTH(MAX_OBSTACLES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[IDX_W-1:0]),
        .wdata({query_z, query_y, query_x}),
        .raddr(idx_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    // accumulator update from the registered product
    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        case (sh_reg)
            SH_LIMB:  prod_sh = prod_ext <<< LIMB_W;
            SH_LIMB2: prod_sh = prod_ext <<< (2 * LIMB_W);
            default:  prod_sh = prod_ext;
        endcase
        case (mode_reg)
            ACC_LOAD: acc_next = prod_sh;
            ACC_ADD:  acc_next = acc_reg + prod_sh;
            ACC_SUB:  acc_next = acc_reg - prod_sh;
            default:  acc_next = acc_reg;
        endcase
        acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    end

    // ------------------------------------------------------------------
    // Output decode: multiplier operands and per-point decisions.
    // Every MAC state waits at step 0 (where some latch the previous sum),
    // issues at steps 1..n and drains at step n+1; the sum is ready on exit.
    // ------------------------------------------------------------------
    always_comb begin
        logic              use_limb;
        logic [WIDE_W-1:0] lim_a, lim_b;

        use_limb = 1'b0;
        lim_a    = '0;
        lim_b    = '0;
        mul_a    = '0;
        mul_b    = '0;
        iss_mode = ACC_NONE;
        iss_sh   = SH_NONE;

        n_prod   = prod_count(state_reg);
        issue    = (step_reg != '0) && (step_reg <= n_prod);
        mac_done = (step_reg == (n_prod + STEP_W'(1)));

        d_val    = acc_reg[WIDE_W-1:0];
        dot_pos  = !acc_reg[ACC_W-1] && (acc_reg != '0);
        ray_skip = (rhs_reg <= acc_reg[SQ_W-1:0]);
        cand     = d_reg | (HIT_W'(1) << bit_reg);
        bit_ok   = (acc_reg[SQ_W-1:0] <= lh_reg);
        d_new    = bit_ok ? cand : d_reg;
        last_pt  = ((idx_reg + CNT_W'(1)) == count_reg);
        col_hit  = (state_reg == ST_DIST_CHK) && (op_reg == OP_COLLISION)
                   && (d_val < WIDE_W'(cd2_reg));

        case (state_reg)
            ST_DIST_CHK: best_upd = (op_reg inside {OP_NEAREST, OP_DIRECTION})
                                    && (!res_found_reg || (d_val < bestd_reg));
            ST_RAY_CHK:  best_upd = !ray_skip
                                    && (!res_found_reg || (WIDE_W'(dt_reg) < bestd_reg));
            default:     best_upd = 1'b0;
        endcase

        case (state_reg)
            ST_PRE_CD: begin
                mul_a = MUL_W'(cd_reg);
                mul_b = MUL_W'(cd_reg);
            end
            ST_PRE_AB: begin
                mul_a = (step_reg == STEP_W'(1)) ? MUL_W'(abx_reg) : MUL_W'(aby_reg);
                mul_b = mul_a;
            end
            ST_PRE_RHS: begin
                use_limb = 1'b1;
                lim_a    = WIDE_W'(cd2_reg);
                lim_b    = WIDE_W'(ab2_reg);
            end
            ST_DOT: begin
                case (step_reg)
                    STEP_W'(1): begin mul_a = MUL_W'(dx_reg); mul_b = MUL_W'(sx_reg); end
                    STEP_W'(2): begin mul_a = MUL_W'(dy_reg); mul_b = MUL_W'(sy_reg); end
                    default:    begin mul_a = MUL_W'(dz_reg); mul_b = MUL_W'(sz_reg); end
                endcase
            end
            ST_DIST: begin
                case (step_reg)
                    STEP_W'(1): mul_a = MUL_W'(dx_reg);
                    STEP_W'(2): mul_a = MUL_W'(dy_reg);
                    default:    mul_a = MUL_W'(dz_reg);
                endcase
                mul_b = mul_a;
            end
            // cross product up to sign: aby*dx - abx*dy
            ST_CROSS: begin
                if (step_reg == STEP_W'(1)) begin
                    mul_a = MUL_W'(aby_reg);
                    mul_b = MUL_W'(dx_reg);
                end else begin
                    mul_a = MUL_W'(abx_reg);
                    mul_b = MUL_W'(dy_reg);
                end
            end
            // projection up to sign: abx*dx + aby*dy
            ST_DT: begin
                if (step_reg == STEP_W'(1)) begin
                    mul_a = MUL_W'(abx_reg);
                    mul_b = MUL_W'(dx_reg);
                end else begin
                    mul_a = MUL_W'(aby_reg);
                    mul_b = MUL_W'(dy_reg);
                end
            end
            ST_CR2: begin
                use_limb = 1'b1;
                lim_a    = WIDE_W'(cr_reg);
                lim_b    = WIDE_W'(cr_reg);
            end
            ST_SQ: begin
                use_limb = 1'b1;
                lim_a    = bestd_reg;
                lim_b    = bestd_reg;
            end
            ST_MM: begin
                mul_a = MUL_W'(cand);
                mul_b = MUL_W'(cand);
            end
            ST_MMAB: begin
                use_limb = 1'b1;
                lim_a    = WIDE_W'(mm_reg);
                lim_b    = WIDE_W'(ab2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        if (issue) begin
            if (step_reg == STEP_W'(1)) begin
                iss_mode = ACC_LOAD;
            end else if (state_reg == ST_CROSS) begin
                iss_mode = ACC_SUB;
            end else begin
                iss_mode = ACC_ADD;
            end
            // limb order: lo*lo, lo*hi, hi*lo, hi*hi
            if (use_limb) begin
                mul_a = limb(lim_a, step_reg >= STEP_W'(3));
                mul_b = limb(lim_b, (step_reg == STEP_W'(2)) || (step_reg == STEP_W'(4)));
                if (step_reg == STEP_W'(1)) begin
                    iss_sh = SH_NONE;
                end else if (step_reg == STEP_W'(4)) begin
                    iss_sh = SH_LIMB2;
                end else begin
                    iss_sh = SH_LIMB;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_t adv;

        // after a point: fetch the next one, or wrap up the query
        if (!last_pt) begin
            adv = ST_RD;
        end else if ((op_reg == OP_RAY) && (res_found_reg || best_upd)) begin
            adv = ST_SQ;
        end else begin
            adv = ST_OUT;
        end

        state_next = state_reg;
        step_next  = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (op)
                        OP_NEAREST, OP_DIRECTION, OP_COLLISION, OP_RAY:
                            state_next = ST_PRE_CD;
                        default:
                            state_next = ST_OUT;
                    endcase
                end
            end
            ST_PRE_CD: begin
                if (mac_done) state_next = ST_PRE_AB;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_PRE_AB: begin
                if ((step_reg == '0) && (count_reg == '0)) begin
                    state_next = ST_OUT;
                end else if ((step_reg == '0) && (op_reg != OP_RAY)) begin
                    state_next = ST_RD;
                end else if (mac_done) begin
                    state_next = ST_PRE_RHS;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_PRE_RHS: begin
                // degenerate ray: start and end share x and y
                if ((step_reg == '0) && (acc_reg == '0)) begin
                    state_next = ST_OUT;
                end else if (mac_done) begin
                    state_next = ST_PRE_END;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_PRE_END: state_next = ST_RD;
            ST_RD:      state_next = ST_DIFF;
            ST_DIFF: begin
                case (op_reg)
                    OP_DIRECTION: state_next = ST_DOT;
                    OP_RAY:       state_next = ST_CROSS;
                    default:      state_next = ST_DIST;
                endcase
            end
            ST_DOT: begin
                if (mac_done) state_next = ST_DOT_CHK;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_DOT_CHK: state_next = dot_pos ? adv : ST_DIST;
            ST_DIST: begin
                if (mac_done) state_next = ST_DIST_CHK;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_DIST_CHK: state_next = col_hit ? ST_OUT : adv;
            ST_CROSS: begin
                if (mac_done) state_next = ST_DT;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_DT: begin
                if (mac_done) state_next = ST_CR2;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_CR2: begin
                if (mac_done) state_next = ST_RAY_CHK;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_RAY_CHK: state_next = adv;
            ST_SQ: begin
                if (mac_done) state_next = ST_LH;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_LH: state_next = ST_MM;
            ST_MM: begin
                if (mac_done) state_next = ST_MMAB;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_MMAB: begin
                if (mac_done) state_next = ST_BIT_CHK;
                else          step_next  = step_reg + STEP_W'(1);
            end
            ST_BIT_CHK: state_next = (bit_reg == '0) ? ST_OUT : ST_MM;
            ST_OUT: begin
                if (out_take) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            cd_reg        <= CD_RESET;
            mode_reg      <= ACC_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mode_reg  <= iss_mode;
            if (cfg_we) begin
                cd_reg <= cfg_wdata;
            end
            if (in_accept && (op == OP_CLEAR)) begin
                count_reg <= '0;
            end else if (ram_we) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if ((state_reg == ST_OUT) && out_take) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk) begin
        prod_reg <= mul_a * mul_b;
        sh_reg   <= iss_sh;
        acc_reg  <= acc_next;

        if (in_accept) begin
            op_reg        <= op;
            qx_reg        <= query_x;
            qy_reg        <= query_y;
            qz_reg        <= query_z;
            sx_reg        <= second_x;
            sy_reg        <= second_y;
            sz_reg        <= second_z;
            abx_reg       <= DIFF_W'(second_x) - DIFF_W'(query_x);
            aby_reg       <= DIFF_W'(second_y) - DIFF_W'(query_y);
            idx_reg       <= '0;
            res_hit_reg   <= '0;
            if (ram_we) begin
                res_found_reg <= 1'b1;
                res_x_reg     <= query_x;
                res_y_reg     <= query_y;
                res_z_reg     <= query_z;
                res_idx_reg   <= count_reg[IDX_W-1:0];
            end else begin
                res_found_reg <= 1'b0;
                res_x_reg     <= '0;
                res_y_reg     <= '0;
                res_z_reg     <= '0;
                res_idx_reg   <= '0;
            end
        end

        case (state_reg)
            ST_PRE_AB: begin
                if (step_reg == '0) cd2_reg <= acc_reg[CD2_W-1:0];
            end
            ST_PRE_RHS: begin
                if (step_reg == '0) ab2_reg <= acc_reg[AB2_W-1:0];
            end
            ST_PRE_END: rhs_reg <= acc_reg[SQ_W-1:0];
            ST_DIFF: begin
                px_reg <= rd_x;
                py_reg <= rd_y;
                pz_reg <= rd_z;
                dx_reg <= DIFF_W'(qx_reg) - DIFF_W'(rd_x);
                dy_reg <= DIFF_W'(qy_reg) - DIFF_W'(rd_y);
                dz_reg <= DIFF_W'(qz_reg) - DIFF_W'(rd_z);
            end
            ST_DOT_CHK: begin
                if (dot_pos) idx_reg <= idx_reg + CNT_W'(1);
            end
            ST_DT: begin
                if (step_reg == '0) cr_reg <= acc_mag[MAG_W-1:0];
            end
            ST_CR2: begin
                if (step_reg == '0) dt_reg <= acc_mag[MAG_W-1:0];
            end
            ST_DIST_CHK, ST_RAY_CHK: begin
                idx_reg <= idx_reg + CNT_W'(1);
                if (col_hit) begin
                    res_found_reg <= 1'b1;
                end
                if (best_upd) begin
                    res_found_reg <= 1'b1;
                    res_x_reg     <= px_reg;
                    res_y_reg     <= py_reg;
                    res_z_reg     <= pz_reg;
                    res_idx_reg   <= idx_reg[IDX_W-1:0];
                    bestd_reg     <= (state_reg == ST_DIST_CHK) ? d_val : WIDE_W'(dt_reg);
                end
            end
            ST_LH: begin
                lh_reg  <= acc_reg[SQ_W-1:0];
                bit_reg <= BIT_W'(HIT_W - 1);
                d_reg   <= '0;
            end
            ST_MMAB: begin
                if (step_reg == '0) mm_reg <= acc_reg[MM_W-1:0];
            end
            ST_BIT_CHK: begin
                d_reg       <= d_new;
                res_hit_reg <= d_new;
                bit_reg     <= bit_reg - BIT_W'(1);
            end
            default: begin
            end
        endcase

        if ((state_reg == ST_OUT) && out_take) begin
            out_found_reg <= res_found_reg;
            out_x_reg     <= res_x_reg;
            out_y_reg     <= res_y_reg;
            out_z_reg     <= res_z_reg;
            out_idx_reg   <= res_idx_reg;
            out_hit_reg   <= res_hit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `NOQE_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != ST_IDLE,
                      "accepted transaction did not start")
    `NOQE_ASSERT_NEXT(a_out_hold, (state_reg == ST_OUT) && out_valid_reg && out_stall,
                      state_reg == ST_OUT, "result overwrote a pending output")
    `NOQE_ASSERT_IMP(a_ram_write, ram_we, count_reg < CNT_W'(MAX_OBSTACLES),
                     "write to a full store")
    `NOQE_ASSERT_IMP(a_loop_idx, state_reg == ST_RD, idx_reg < count_reg,
                     "read beyond the stored points")

endmodule

`default_nettype wire
